FILE: design/crpf_pkg.sv
package crpf_pkg;

  // Table size and derived widths
  localparam int MaxPoints = 16;
  localparam int IdxW      = $clog2(MaxPoints);
  localparam int CntW      = $clog2(MaxPoints + 1);

  // Field widths fixed by the interface
  localparam int CoordW   = 24;
  localparam int PointW   = 3 * CoordW;
  localparam int DeltaW   = 16;
  localparam int PidxW    = 4;
  localparam int TimeW    = 32;
  localparam int SpeedW   = 16;
  localparam int CountW   = 5;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  // Progress product, Q24.24
  localparam int ProdW = TimeW + SpeedW;
  localparam int FracW = 16;
  localparam int DivW  = ProdW - 24;

  // Iterative ring modulo: bits retired per cycle
  localparam int ModBits  = 3;
  localparam int ModSteps = DivW / ModBits;
  localparam int ModCntW  = $clog2(ModSteps);

  // Horner accumulator, covers |a|+|b|+|c|+|d| of Q15.8 inputs
  localparam int HornW = CoordW + 6;

  localparam int PosMax = 2 ** (CoordW - 1) - 1;
  localparam int PosMin = -(2 ** (CoordW - 1));

  localparam logic OpLoad = 1'b0;
  localparam logic OpTick = 1'b1;

  localparam logic [CfgIdxW-1:0] CfgPathSpeed  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgPointCount = CfgIdxW'(1);

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [CntW-1:0] count;
  } crpf_mod_req_t;

  typedef struct packed {
    logic            done;
    logic [IdxW-1:0] rem;
  } crpf_mod_rsp_t;

endpackage

FILE: design/crpf_if.sv
interface crpf_in_if import crpf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [DeltaW-1:0]        delta_time;
  logic [PidxW-1:0]         point_index;
  logic signed [CoordW-1:0] point_x;
  logic signed [CoordW-1:0] point_y;
  logic signed [CoordW-1:0] point_z;

  modport source (output valid, operation, delta_time, point_index, point_x, point_y,
                  point_z, input ready);
  modport sink (input valid, operation, delta_time, point_index, point_x, point_y,
                point_z, output ready);
endinterface

interface crpf_out_if import crpf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] pos_x;
  logic signed [CoordW-1:0] pos_y;
  logic signed [CoordW-1:0] pos_z;
  logic                     at_final;

  modport source (output valid, pos_x, pos_y, pos_z, at_final, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, at_final, output ready);
endinterface

interface crpf_cfg_if import crpf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: design/catmull_rom_path_follower_core.sv
// Closed-ring Catmull-Rom path follower. A load transaction writes one waypoint into
// the 16-entry table; it gives no result. A tick transaction adds its time step to
// the saturating elapsed time and then delivers one interpolated position (sooner
// when the current point matches the final point, which skips the spline). A tick
// runs an iterative ring modulo (3 bits per cycle over the 24-bit segment number),
// five reads through the single table read port and nine Horner products through
// one shared multiplier. Items
// are handled one at a time; the input is ready whenever the sequencer is idle, even
// while the previous result still waits in the output register. Table entries have
// no reset and must be loaded before a tick reads them; configuration is always
// ready and must only be written while the block is idle.
module catmull_rom_path_follower_core import crpf_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  crpf_in_if.sink  in_i,
  crpf_out_if.source out_o,
  crpf_cfg_if.sink cfg_i
);

  // Sequencer states
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SMul  = 3'd1;
  localparam logic [2:0] SMod  = 3'd2;
  localparam logic [2:0] SRead = 3'd3;
  localparam logic [2:0] SCoef = 3'd4;
  localparam logic [2:0] SHorn = 3'd5;
  localparam logic [2:0] SOut  = 3'd6;

  localparam int MulW = HornW + FracW + 1;
  localparam logic signed [HornW-1:0] HPosMax = HornW'(PosMax);
  localparam logic signed [HornW-1:0] HPosMin = HornW'(PosMin);

  logic [2:0] state_q, state_d;

  // Configuration
  logic [SpeedW-1:0] speed_q;
  logic [CountW-1:0] count_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= SpeedW'(256);
      count_q <= CountW'(16);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgPathSpeed:  speed_q <= cfg_i.data[SpeedW-1:0];
        CfgPointCount: count_q <= cfg_i.data[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Ring size clamped to [4, MaxPoints]
  logic [CntW-1:0] cnt_eff;

  always_comb begin
    if (32'(count_q) < 32'(4)) begin
      cnt_eff = CntW'(4);
    end else if (32'(count_q) > 32'(MaxPoints)) begin
      cnt_eff = CntW'(MaxPoints);
    end else begin
      cnt_eff = CntW'(count_q);
    end
  end

  // Input acceptance
  logic in_acc, load_acc, tick_acc;

  assign in_i.ready = (state_q == SIdle);
  assign in_acc     = in_i.valid && in_i.ready;
  assign load_acc   = in_acc && (in_i.operation == OpLoad);
  assign tick_acc   = in_acc && (in_i.operation == OpTick);

  // Elapsed time, saturating Q16.16
  logic [TimeW-1:0] elapsed_q;
  logic [TimeW:0]   elapsed_sum;

  assign elapsed_sum = {1'b0, elapsed_q} + (TimeW + 1)'(in_i.delta_time);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
    end else if (tick_acc) begin
      elapsed_q <= elapsed_sum[TimeW] ? '1 : elapsed_sum[TimeW-1:0];
    end
  end

  // Progress = elapsed * speed, Q24.24
  logic [ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (state_q == SMul) begin
      prod_q <= ProdW'(elapsed_q) * ProdW'(speed_q);
    end
  end

  // Ring modulo of the segment number
  crpf_mod_req_t mod_req;
  crpf_mod_rsp_t mod_rsp;
  logic          mod_start_q;
  logic [IdxW-1:0] cur_q;

  assign mod_req.start    = mod_start_q;
  assign mod_req.dividend = prod_q[ProdW-1 -: DivW];
  assign mod_req.count    = cnt_eff;

  crpf_ring_mod u_mod (
    .clk_i,
    .rst_ni,
    .req_i(mod_req),
    .rsp_o(mod_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_start_q <= 1'b0;
    end else begin
      mod_start_q <= (state_q == SMul);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SMod && mod_rsp.done) begin
      cur_q <= mod_rsp.rem;
    end
  end

  // Neighbor indices around the ring
  logic [IdxW-1:0] prv_idx, nxt_idx, nn_idx, fin_idx;
  logic [CntW-1:0] cur_p1, nxt_p1;

  always_comb begin
    prv_idx = (cur_q == '0) ? IdxW'(cnt_eff - CntW'(1)) : cur_q - IdxW'(1);
    cur_p1  = CntW'(cur_q) + CntW'(1);
    nxt_idx = (cur_p1 == cnt_eff) ? '0 : IdxW'(cur_p1);
    nxt_p1  = CntW'(nxt_idx) + CntW'(1);
    nn_idx  = (nxt_p1 == cnt_eff) ? '0 : IdxW'(nxt_p1);
    fin_idx = IdxW'(cnt_eff - CntW'(3));
  end

  // Waypoint table: one write, one registered read
  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr, ram_raddr;
  logic [PointW-1:0] ram_wdata, ram_rdata;
  logic [2:0]        rd_cnt_q;

  // Writes past the table are dropped
  assign ram_we    = load_acc && (32'(in_i.point_index) < 32'(MaxPoints));
  assign ram_waddr = IdxW'(in_i.point_index);
  assign ram_wdata = {in_i.point_z, in_i.point_y, in_i.point_x};

  // Read order: previous, current, next, next-next, final
  always_comb begin
    unique case (rd_cnt_q)
      3'd0:    ram_raddr = prv_idx;
      3'd1:    ram_raddr = cur_q;
      3'd2:    ram_raddr = nxt_idx;
      3'd3:    ram_raddr = nn_idx;
      default: ram_raddr = fin_idx;
    endcase
  end

  crpf_ram #(
    .Width(PointW),
    .Depth(MaxPoints)
  ) u_table (
    .clk_i,
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  logic [PointW-1:0] pt_q [5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_cnt_q <= '0;
    end else if (state_q == SRead) begin
      rd_cnt_q <= (rd_cnt_q == 3'd5) ? '0 : rd_cnt_q + 3'd1;
    end
  end

  // Read data arrives in the cycle after its address
  always_ff @(posedge clk_i) begin
    if (state_q == SRead && rd_cnt_q != 3'd0) begin
      pt_q[rd_cnt_q - 3'd1] <= ram_rdata;
    end
  end

  logic is_final;
  assign is_final = (pt_q[1] == pt_q[4]);

  // Spline coefficients per axis; coef index 0 = c, 1 = b, 2 = a
  logic signed [HornW-1:0] coef_d [3][3];
  logic signed [HornW-1:0] d_d [3];

  always_comb begin
    logic signed [HornW-1:0] p0, p1, p2, p3;
    for (int ax = 0; ax < 3; ax++) begin
      p0 = HornW'($signed(pt_q[0][ax*CoordW +: CoordW]));
      p1 = HornW'($signed(pt_q[1][ax*CoordW +: CoordW]));
      p2 = HornW'($signed(pt_q[2][ax*CoordW +: CoordW]));
      p3 = HornW'($signed(pt_q[3][ax*CoordW +: CoordW]));
      coef_d[2][ax] = p1 + p1;
      coef_d[1][ax] = p2 - p0;
      coef_d[0][ax] = (p0 <<< 1) - (p1 <<< 2) - p1 + (p2 <<< 2) - p3;
      d_d[ax]       = (p1 <<< 1) + p1 - (p2 <<< 1) - p2 + p3 - p0;
    end
  end

  // Horner evaluation on one shared multiplier. Issue order walks the three axes
  // per step, so an axis is re-read only after its write-back.
  logic signed [HornW-1:0] coef_q [3][3];
  logic signed [HornW-1:0] h_q [3];
  logic [FracW-1:0]        t_q;
  logic signed [MulW-1:0]  mul_q;
  logic [1:0]              ax_q, st_q, wb_ax_q, wb_st_q;
  logic                    iss_done_q, wb_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ax_q       <= '0;
      st_q       <= '0;
      iss_done_q <= 1'b0;
      wb_v_q     <= 1'b0;
    end else if (state_q == SHorn) begin
      wb_v_q <= !iss_done_q;
      if (!iss_done_q) begin
        if (ax_q == 2'd2) begin
          ax_q <= '0;
          if (st_q == 2'd2) begin
            st_q       <= '0;
            iss_done_q <= 1'b1;
          end else begin
            st_q <= st_q + 2'd1;
          end
        end else begin
          ax_q <= ax_q + 2'd1;
        end
      end
    end else begin
      ax_q       <= '0;
      st_q       <= '0;
      iss_done_q <= 1'b0;
      wb_v_q     <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SCoef) begin
      coef_q <= coef_d;
      h_q    <= d_d;
      t_q    <= prod_q[FracW+7:8];
    end else if (state_q == SHorn) begin
      if (!iss_done_q) begin
        wb_ax_q <= ax_q;
        wb_st_q <= st_q;
        mul_q   <= h_q[ax_q] * $signed({1'b0, t_q});
      end
      // floor(h*t / 2^16) + coefficient
      if (wb_v_q) begin
        h_q[wb_ax_q] <= HornW'(mul_q >>> FracW) + coef_q[wb_st_q][wb_ax_q];
      end
    end
  end

  // Final scaling floor(h/2) and saturation; zero when at the final point
  logic signed [CoordW-1:0] pos_d [3];

  always_comb begin
    logic signed [HornW-1:0] hs;
    for (int ax = 0; ax < 3; ax++) begin
      hs = h_q[ax] >>> 1;
      if (is_final) begin
        pos_d[ax] = '0;
      end else if (hs > HPosMax) begin
        pos_d[ax] = CoordW'(HPosMax);
      end else if (hs < HPosMin) begin
        pos_d[ax] = CoordW'(HPosMin);
      end else begin
        pos_d[ax] = CoordW'(hs);
      end
    end
  end

  // Output register
  logic                     out_valid_q;
  logic signed [CoordW-1:0] pos_q [3];
  logic                     final_q;
  logic                     out_load;

  assign out_load = (state_q == SOut) && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pos_q   <= pos_d;
      final_q <= is_final;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.pos_x    = pos_q[0];
  assign out_o.pos_y    = pos_q[1];
  assign out_o.pos_z    = pos_q[2];
  assign out_o.at_final = final_q;

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle:   if (tick_acc) state_d = SMul;
      SMul:    state_d = SMod;
      SMod:    if (mod_rsp.done) state_d = SRead;
      SRead:   if (rd_cnt_q == 3'd5) state_d = SCoef;
      SCoef:   state_d = is_final ? SOut : SHorn;
      SHorn:   if (iss_done_q && wb_v_q) state_d = SOut;
      SOut:    if (out_load) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Checks
  a_final_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && final_q |-> pos_q[0] == '0 && pos_q[1] == '0 && pos_q[2] == '0)
    else $error("final-point result carries nonzero position");

  a_mod_done_in_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_rsp.done |-> state_q == SMod)
    else $error("modulo finished outside its wait state");

  a_cur_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SRead |-> CntW'(cur_q) < cnt_eff)
    else $error("current index outside ring");

  a_wb_in_horner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_v_q |-> state_q == SHorn)
    else $error("Horner write-back outside evaluation");

  a_tick_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc |=> state_q == SMul && mod_start_q == 1'b0)
    else $error("tick did not start the progress product");

endmodule

FILE: design/crpf_ram.sv
module crpf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/crpf_ring_mod.sv
// Iterative remainder of progress index by ring size, ModBits bits per cycle.
module crpf_ring_mod import crpf_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  crpf_mod_req_t req_i,
  output crpf_mod_rsp_t rsp_o
);

  localparam int RemW = CntW + 1;

  logic               busy_q;
  logic               done_q;
  logic [ModCntW-1:0] cnt_q;
  logic [DivW-1:0]    sh_q, sh_d;
  logic [RemW-1:0]    r_q, r_d;

  always_comb begin
    logic [RemW-1:0] r;
    logic [DivW-1:0] sh;
    r  = r_q;
    sh = sh_q;
    for (int i = 0; i < ModBits; i++) begin
      r  = {r[RemW-2:0], sh[DivW-1]};
      sh = sh << 1;
      if (r >= RemW'(req_i.count)) begin
        r = r - RemW'(req_i.count);
      end
    end
    r_d  = r;
    sh_d = sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + ModCntW'(1);
        if (cnt_q == ModCntW'(ModSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      r_q  <= '0;
      sh_q <= req_i.dividend;
    end else if (busy_q) begin
      r_q  <= r_d;
      sh_q <= sh_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = IdxW'(r_q);

endmodule
